// File: hw/rtl/asf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asf_pkg
// Shared types, constants and helper functions of the arrive steering follower.
// ----------------------------------------------------------------------------
package asf_pkg;

    localparam int FRAC_BITS = 16;
    localparam int CFG_AW    = 5;
    localparam int DIV_QW    = 34;
    localparam int SAT_W     = 51;

    localparam logic [49:0] STEP_MASK = (50'd1 << FRAC_BITS) - 50'd1;

    localparam logic [1:0] ACT_TICK = 2'd0;
    localparam logic [1:0] ACT_JUMP = 2'd1;
    localparam logic [1:0] ACT_MOVE = 2'd2;

    localparam logic [2:0] REG_SLOW_RADIUS = 3'd0;
    localparam logic [2:0] REG_MAX_SPEED   = 3'd1;
    localparam logic [2:0] REG_MAX_STEER   = 3'd2;
    localparam logic [2:0] REG_STOP_SPEED  = 3'd3;
    localparam logic [2:0] REG_STOP_RADIUS = 3'd4;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [31:0] goal_x;
        logic signed [31:0] goal_y;
        logic [17:0]        tick_delta;
    } asf_in_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
    } asf_out_t;

    typedef struct packed {
        logic [30:0] slow_radius;
        logic [30:0] max_speed;
        logic [30:0] max_steer;
        logic [30:0] stop_speed;
        logic [30:0] stop_radius;
    } asf_cfg_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DIFF,
        ST_DSQ_X,
        ST_DSQ_Y,
        ST_DSUM,
        ST_DSTOP,
        ST_VSQ_X,
        ST_VSQ_Y,
        ST_VSUM,
        ST_VCMP,
        ST_DROOT,
        ST_SPD_MUL,
        ST_SPD_DIV,
        ST_SPD_WAIT,
        ST_DES,
        ST_SCL_MUL,
        ST_SCL_DIV,
        ST_SCL_WAIT,
        ST_STEER,
        ST_SSQ_X,
        ST_SSQ_Y,
        ST_SSUM,
        ST_SCMP,
        ST_SROOT,
        ST_UPDATE,
        ST_STEP_X,
        ST_STEP_Y,
        ST_STEP_END,
        ST_DONE
    } asf_state_t;

    function automatic logic [32:0] abs33(input logic signed [32:0] v);
        return v[32] ? 33'(-v) : 33'(v);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
        logic signed [SAT_W-1:0] hi;
        logic signed [SAT_W-1:0] lo;
        hi = $signed({{(SAT_W-32){1'b0}}, 32'h7fff_ffff});
        lo = $signed({{(SAT_W-32){1'b1}}, 32'h8000_0000});
        if (v > hi) begin
            return 32'sh7fff_ffff;
        end else if (v < lo) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

endpackage

// File: hw/rtl/arrive_steering_follower.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arrive_steering_follower
// 2D arrive steering follower in signed Q16.16, run by a sequencer over one
// shared multiplier, an iterative divider and an iterative square root.
//
// s_* carries a request (action, goal, tick_delta); m_* returns the position
// after it, one result per request. Limits sit in APB registers at 4*i.
// Jump, move and the unused code go straight from idle to the done state.
// A tick runs one or two square roots and up to five divides in the
// shared divider, plus the multiply steps of the shared multiplier.
// s_ready is high only while the sequencer is idle: one request at a time.
// The result sits in an output register; the next request is taken while
// it waits, and a finished result waits there until m_ready.
// Reset clears position, velocity and targets and loads the default limits;
// the block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
module arrive_steering_follower (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  asf_pkg::asf_in_t           s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output asf_pkg::asf_out_t          m_data,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [asf_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import asf_pkg::*;

    asf_cfg_t   cfg;
    asf_state_t state_reg, state_next;

    logic signed [31:0] cx_reg, cx_next, cy_reg, cy_next;
    logic signed [31:0] vx_reg, vx_next, vy_reg, vy_next;
    logic signed [31:0] tx_reg, tx_next, ty_reg, ty_next;
    logic signed [31:0] px_reg, px_next, py_reg, py_next;
    logic signed [31:0] desx_reg, desx_next, desy_reg, desy_next;
    logic signed [32:0] dx_reg, dx_next, dy_reg, dy_next;
    logic signed [32:0] sx_reg, sx_next, sy_reg, sy_next;
    logic [17:0]        delta_reg, delta_next;
    logic [63:0]        acc_reg, acc_next, sum_reg, sum_next;
    logic [32:0]        dist_reg, dist_next, mlen_reg, mlen_next;
    logic [30:0]        speed_reg, speed_next;
    logic               in_slow_reg, in_slow_next, in_stop_reg, in_stop_next;
    logic               slow_v_reg, slow_v_next;
    logic               comp_reg, comp_next, phase_reg, phase_next;
    logic               m_valid_reg, m_valid_next;
    asf_out_t           m_data_reg, m_data_next;

    logic [32:0] mul_a;
    logic [31:0] mul_b;
    logic [64:0] mul_q;
    logic        div_start, div_done;
    logic [32:0] div_den;
    logic [DIV_QW-1:0] div_quo;
    logic        sqrt_start, sqrt_done;
    logic [31:0] sqrt_root;

    logic [32:0] adx, ady, asx, asy, avx, avy;
    logic        dbig, sbig, neg_sel, snap;
    logic [31:0] hdx, hdy, hsx, hsy;
    logic signed [SAT_W-1:0] qv, qs, stepv;

    function automatic logic signed [SAT_W-1:0] step_of(input logic neg,
                                                        input logic [48:0] p);
        logic [49:0] t;
        t = {1'b0, p} + (neg ? STEP_MASK : 50'd0);
        t = t >> FRAC_BITS;
        return neg ? -$signed({1'b0, t}) : $signed({1'b0, t});
    endfunction

    asf_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    asf_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .p    (mul_q)
    );

    asf_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (mul_q[63:0]),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo)
    );

    asf_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sqrt_start),
        .rad     (sum_reg),
        .done    (sqrt_done),
        .root    (sqrt_root)
    );

    assign adx  = abs33(dx_reg);
    assign ady  = abs33(dy_reg);
    assign dbig = adx[32] | adx[31] | ady[32] | ady[31];
    assign hdx  = dbig ? adx[32:1] : adx[31:0];
    assign hdy  = dbig ? ady[32:1] : ady[31:0];
    assign asx  = abs33(sx_reg);
    assign asy  = abs33(sy_reg);
    assign sbig = asx[32] | asx[31] | asy[32] | asy[31];
    assign hsx  = sbig ? asx[32:1] : asx[31:0];
    assign hsy  = sbig ? asy[32:1] : asy[31:0];
    assign avx  = abs33(33'(vx_reg));
    assign avy  = abs33(33'(vy_reg));

    // sign of the component being scaled and its signed quotient
    assign neg_sel = phase_reg ? (comp_reg ? sy_reg[32] : sx_reg[32])
                               : (comp_reg ? dy_reg[32] : dx_reg[32]);
    assign qv    = $signed(SAT_W'(div_quo));
    assign qs    = neg_sel ? -qv : qv;
    assign stepv = (state_reg == ST_STEP_Y) ? step_of(vx_reg[31], mul_q[48:0])
                                            : step_of(vy_reg[31], mul_q[48:0]);
    assign snap  = slow_v_reg && in_stop_reg && (tx_reg == px_reg) && (ty_reg == py_reg);

    always_comb begin
        state_next   = state_reg;
        cx_next      = cx_reg;
        cy_next      = cy_reg;
        vx_next      = vx_reg;
        vy_next      = vy_reg;
        tx_next      = tx_reg;
        ty_next      = ty_reg;
        px_next      = px_reg;
        py_next      = py_reg;
        desx_next    = desx_reg;
        desy_next    = desy_reg;
        dx_next      = dx_reg;
        dy_next      = dy_reg;
        sx_next      = sx_reg;
        sy_next      = sy_reg;
        delta_next   = delta_reg;
        acc_next     = acc_reg;
        sum_next     = sum_reg;
        dist_next    = dist_reg;
        mlen_next    = mlen_reg;
        speed_next   = speed_reg;
        in_slow_next = in_slow_reg;
        in_stop_next = in_stop_reg;
        slow_v_next  = slow_v_reg;
        comp_next    = comp_reg;
        phase_next   = phase_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        mul_a        = '0;
        mul_b        = '0;
        div_start    = 1'b0;
        div_den      = '0;
        sqrt_start   = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_DONE;
                    case (s_data.action)
                        ACT_TICK: begin
                            delta_next = s_data.tick_delta;
                            state_next = ST_DIFF;
                        end
                        ACT_JUMP: begin
                            px_next = s_data.goal_x;
                            py_next = s_data.goal_y;
                            tx_next = s_data.goal_x;
                            ty_next = s_data.goal_y;
                        end
                        ACT_MOVE: begin
                            px_next = tx_reg;
                            py_next = ty_reg;
                            tx_next = s_data.goal_x;
                            ty_next = s_data.goal_y;
                        end
                        default: ;
                    endcase
                end
            end
            ST_DIFF: begin
                dx_next    = 33'(tx_reg) - 33'(cx_reg);
                dy_next    = 33'(ty_reg) - 33'(cy_reg);
                state_next = ST_DSQ_X;
            end
            ST_DSQ_X: begin
                mul_a      = 33'(hdx);
                mul_b      = hdx;
                state_next = ST_DSQ_Y;
            end
            ST_DSQ_Y: begin
                mul_a      = 33'(hdy);
                mul_b      = hdy;
                acc_next   = mul_q[63:0];
                state_next = ST_DSUM;
            end
            ST_DSUM: begin
                mul_a      = 33'(cfg.slow_radius);
                mul_b      = 32'(cfg.slow_radius);
                sum_next   = acc_reg + mul_q[63:0];
                state_next = ST_DSTOP;
            end
            ST_DSTOP: begin
                mul_a        = 33'(cfg.stop_radius);
                mul_b        = 32'(cfg.stop_radius);
                in_slow_next = !dbig && (sum_reg <= mul_q[63:0]);
                sqrt_start   = 1'b1;
                state_next   = ST_VSQ_X;
            end
            ST_VSQ_X: begin
                mul_a        = avx;
                mul_b        = avx[31:0];
                in_stop_next = !dbig && (sum_reg <= mul_q[63:0]);
                state_next   = ST_VSQ_Y;
            end
            ST_VSQ_Y: begin
                mul_a      = avy;
                mul_b      = avy[31:0];
                acc_next   = mul_q[63:0];
                state_next = ST_VSUM;
            end
            ST_VSUM: begin
                mul_a      = 33'(cfg.stop_speed);
                mul_b      = 32'(cfg.stop_speed);
                acc_next   = acc_reg + mul_q[63:0];
                state_next = ST_VCMP;
            end
            ST_VCMP: begin
                slow_v_next = acc_reg <= mul_q[63:0];
                state_next  = ST_DROOT;
            end
            ST_DROOT: begin
                if (sqrt_done) begin
                    dist_next = dbig ? {sqrt_root, 1'b0} : {1'b0, sqrt_root};
                    if (!in_slow_reg) begin
                        speed_next = cfg.max_speed;
                        state_next = ST_DES;
                    end else if (cfg.slow_radius != '0) begin
                        state_next = ST_SPD_MUL;
                    end else begin
                        speed_next = '0;
                        state_next = ST_DES;
                    end
                end
            end
            ST_SPD_MUL: begin
                mul_a      = dist_reg;
                mul_b      = 32'(cfg.max_speed);
                state_next = ST_SPD_DIV;
            end
            ST_SPD_DIV: begin
                div_start  = 1'b1;
                div_den    = 33'(cfg.slow_radius);
                state_next = ST_SPD_WAIT;
            end
            ST_SPD_WAIT: begin
                if (div_done) begin
                    speed_next = div_quo[30:0];
                    state_next = ST_DES;
                end
            end
            ST_DES: begin
                comp_next  = 1'b0;
                phase_next = 1'b0;
                if (dist_reg == '0) begin
                    desx_next  = '0;
                    desy_next  = '0;
                    state_next = ST_STEER;
                end else begin
                    state_next = ST_SCL_MUL;
                end
            end
            ST_SCL_MUL: begin
                if (phase_reg) begin
                    mul_a = comp_reg ? asy : asx;
                    mul_b = 32'(cfg.max_steer);
                end else begin
                    mul_a = comp_reg ? ady : adx;
                    mul_b = 32'(speed_reg);
                end
                state_next = ST_SCL_DIV;
            end
            ST_SCL_DIV: begin
                div_start  = 1'b1;
                div_den    = phase_reg ? mlen_reg : dist_reg;
                state_next = ST_SCL_WAIT;
            end
            ST_SCL_WAIT: begin
                if (div_done) begin
                    if (phase_reg) begin
                        if (comp_reg) begin
                            sy_next = qs[32:0];
                        end else begin
                            sx_next = qs[32:0];
                        end
                    end else begin
                        if (comp_reg) begin
                            desy_next = sat32(qs);
                        end else begin
                            desx_next = sat32(qs);
                        end
                    end
                    if (!comp_reg) begin
                        comp_next  = 1'b1;
                        state_next = ST_SCL_MUL;
                    end else begin
                        comp_next  = 1'b0;
                        state_next = phase_reg ? ST_UPDATE : ST_STEER;
                    end
                end
            end
            ST_STEER: begin
                sx_next    = 33'(desx_reg) - 33'(vx_reg);
                sy_next    = 33'(desy_reg) - 33'(vy_reg);
                state_next = ST_SSQ_X;
            end
            ST_SSQ_X: begin
                mul_a      = 33'(hsx);
                mul_b      = hsx;
                state_next = ST_SSQ_Y;
            end
            ST_SSQ_Y: begin
                mul_a      = 33'(hsy);
                mul_b      = hsy;
                acc_next   = mul_q[63:0];
                state_next = ST_SSUM;
            end
            ST_SSUM: begin
                mul_a      = 33'(cfg.max_steer);
                mul_b      = 32'(cfg.max_steer);
                sum_next   = acc_reg + mul_q[63:0];
                state_next = ST_SCMP;
            end
            ST_SCMP: begin
                if (!sbig && (sum_reg <= mul_q[63:0])) begin
                    state_next = ST_UPDATE;
                end else begin
                    sqrt_start = 1'b1;
                    state_next = ST_SROOT;
                end
            end
            ST_SROOT: begin
                if (sqrt_done) begin
                    mlen_next  = sbig ? {sqrt_root, 1'b0} : {1'b0, sqrt_root};
                    comp_next  = 1'b0;
                    phase_next = 1'b1;
                    state_next = (sqrt_root == '0) ? ST_UPDATE : ST_SCL_MUL;
                end
            end
            ST_UPDATE: begin
                if (snap) begin
                    vx_next    = '0;
                    vy_next    = '0;
                    cx_next    = tx_reg;
                    cy_next    = ty_reg;
                    state_next = ST_DONE;
                end else begin
                    vx_next    = sat32(SAT_W'(vx_reg) + SAT_W'(sx_reg));
                    vy_next    = sat32(SAT_W'(vy_reg) + SAT_W'(sy_reg));
                    state_next = ST_STEP_X;
                end
            end
            ST_STEP_X: begin
                mul_a      = avx;
                mul_b      = 32'(delta_reg);
                state_next = ST_STEP_Y;
            end
            ST_STEP_Y: begin
                mul_a      = avy;
                mul_b      = 32'(delta_reg);
                cx_next    = sat32(SAT_W'(cx_reg) + stepv);
                state_next = ST_STEP_END;
            end
            ST_STEP_END: begin
                cy_next    = sat32(SAT_W'(cy_reg) + stepv);
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next      = 1'b1;
                    m_data_next.pos_x = cx_reg;
                    m_data_next.pos_y = cy_reg;
                    state_next        = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            cx_reg      <= '0;
            cy_reg      <= '0;
            vx_reg      <= '0;
            vy_reg      <= '0;
            tx_reg      <= '0;
            ty_reg      <= '0;
            px_reg      <= '0;
            py_reg      <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            cx_reg      <= cx_next;
            cy_reg      <= cy_next;
            vx_reg      <= vx_next;
            vy_reg      <= vy_next;
            tx_reg      <= tx_next;
            ty_reg      <= ty_next;
            px_reg      <= px_next;
            py_reg      <= py_next;
        end
        desx_reg    <= desx_next;
        desy_reg    <= desy_next;
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
        sx_reg      <= sx_next;
        sy_reg      <= sy_next;
        delta_reg   <= delta_next;
        acc_reg     <= acc_next;
        sum_reg     <= sum_next;
        dist_reg    <= dist_next;
        mlen_reg    <= mlen_next;
        speed_reg   <= speed_next;
        in_slow_reg <= in_slow_next;
        in_stop_reg <= in_stop_next;
        slow_v_reg  <= slow_v_next;
        comp_reg    <= comp_next;
        phase_reg   <= phase_next;
        m_data_reg  <= m_data_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
endmodule

// File: hw/rtl/asf_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asf_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module asf_mul (
    input  logic        aclk,
    input  logic [32:0] a,
    input  logic [31:0] b,
    output logic [64:0] p
);
    logic [64:0] p_reg;

    always_ff @(posedge aclk) begin
        p_reg <= 65'(a) * 65'(b);
    end

    assign p = p_reg;
endmodule

// File: hw/rtl/asf_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asf_div
// Restoring divider, one quotient bit per cycle, quotient known to be narrow.
// ----------------------------------------------------------------------------
module asf_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [63:0]                num,
    input  logic [32:0]                den,
    output logic                       done,
    output logic [asf_pkg::DIV_QW-1:0] quo
);
    import asf_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [5:0]        cnt_reg, cnt_next;
    logic [32:0]       rem_reg, rem_next;
    logic [DIV_QW-1:0] low_reg, low_next;
    logic [32:0]       den_reg, den_next;
    logic [33:0]       trial;
    logic              fits;

    assign trial = {rem_reg, low_reg[DIV_QW-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        low_next  = low_reg;
        den_next  = den_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = 6'(DIV_QW);
            rem_next  = 33'(num[63:DIV_QW]);
            low_next  = num[DIV_QW-1:0];
            den_next  = den;
        end else if (busy_reg) begin
            rem_next = fits ? 33'(trial - {1'b0, den_reg}) : trial[32:0];
            low_next = {low_reg[DIV_QW-2:0], fits};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        low_reg <= low_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = low_reg;
endmodule

// File: hw/rtl/asf_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asf_sqrt
// Digit-by-digit integer square root of a 64-bit value, two bits per cycle.
// ----------------------------------------------------------------------------
module asf_sqrt (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] rad,
    output logic        done,
    output logic [31:0] root
);
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [63:0] n_reg, n_next;
    logic [63:0] res_reg, res_next;
    logic [63:0] bit_reg, bit_next;
    logic [63:0] trial;

    assign trial = res_reg + bit_reg;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        n_next    = n_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        if (start) begin
            busy_next = 1'b1;
            n_next    = rad;
            res_next  = '0;
            bit_next  = 64'd1 << 62;
        end else if (busy_reg) begin
            if (n_reg >= trial) begin
                n_next   = n_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end else begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg[0]) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        n_reg   <= n_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign done = done_reg;
    assign root = res_reg[31:0];
endmodule

// File: hw/rtl/asf_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asf_cfg
// APB register file holding the steering limits.
// ----------------------------------------------------------------------------
module asf_cfg (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [asf_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output asf_pkg::asf_cfg_t          cfg
);
    import asf_pkg::*;

    asf_cfg_t   cfg_reg, cfg_next;
    logic [2:0] idx;

    assign idx = paddr[4:2];

    always_comb begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite) begin
            unique case (idx)
                REG_SLOW_RADIUS: cfg_next.slow_radius = pwdata[30:0];
                REG_MAX_SPEED:   cfg_next.max_speed   = pwdata[30:0];
                REG_MAX_STEER:   cfg_next.max_steer   = pwdata[30:0];
                REG_STOP_SPEED:  cfg_next.stop_speed  = pwdata[30:0];
                REG_STOP_RADIUS: cfg_next.stop_radius = pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_SLOW_RADIUS: prdata = {1'b0, cfg_reg.slow_radius};
            REG_MAX_SPEED:   prdata = {1'b0, cfg_reg.max_speed};
            REG_MAX_STEER:   prdata = {1'b0, cfg_reg.max_steer};
            REG_STOP_SPEED:  prdata = {1'b0, cfg_reg.stop_speed};
            REG_STOP_RADIUS: prdata = {1'b0, cfg_reg.stop_radius};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.slow_radius <= 31'd262144;
            cfg_reg.max_speed   <= 31'd655360;
            cfg_reg.max_steer   <= 31'd65536;
            cfg_reg.stop_speed  <= 31'd6554;
            cfg_reg.stop_radius <= 31'd6554;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign pready = 1'b1;
    assign cfg    = cfg_reg;
endmodule

// File: hw/rtl/asf_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asf_chk
// Port-level checks of the arrive steering follower, bound to the top level.
// ----------------------------------------------------------------------------
module asf_chk (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input asf_pkg::asf_out_t m_data
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result dropped or changed while stalled");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while busy");

    a_no_early: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !m_valid || $stable(m_data))
        else $error("result appeared in the cycle after a request");
endmodule

bind arrive_steering_follower asf_chk u_asf_chk (.*);
